@@ src/ile3d_pkg.sv @@
// Shared types and constants for the Ising local energy block.
package ile3d_pkg;

    // Configuration register indexes
    localparam logic REG_GRID_EDGE = 1'b0;
    localparam logic REG_COUPLING  = 1'b1;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned COORD_W    = 4;
    localparam int unsigned ENERGY_W   = 19;
    localparam int unsigned COUNT_W    = 3;
    localparam int unsigned S_DATA_W   = 16;
    localparam int unsigned M_DATA_W   = 24;

    // Input kinds carried on tuser
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Gather slots: own site, then -x, +x, -y, +y, -z, +z
    localparam logic [2:0] SLOT_SELF = 3'd0;
    localparam logic [2:0] SLOT_XM   = 3'd1;
    localparam logic [2:0] SLOT_XP   = 3'd2;
    localparam logic [2:0] SLOT_YM   = 3'd3;
    localparam logic [2:0] SLOT_YP   = 3'd4;
    localparam logic [2:0] SLOT_ZM   = 3'd5;
    localparam logic [2:0] SLOT_ZP   = 3'd6;
    localparam logic [2:0] SLOT_LAST = 3'd7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GATHER,
        ST_SCALE,
        ST_EMIT
    } state_t;

endpackage

@@ src/ising_local_energy_3d.sv @@
// Top level: cubic spin grid with per-site Ising local energy queries.
// Write item: one transfer per cycle, ready again on the next cycle.
// Query item: up to 7 single-port store reads (own site, in-grid face neighbours) issued
//   one per gather slot, read latency, one multiply, one output load (held while the output
//   holds an untaken result), then next accept; out-of-range query: straight to the output load.
// Reset (aresetn low, synchronous): grid_edge 10, coupling 1.0, then a clearing pass
//   sets all EDGE_MAX^3 spins up, input not ready meanwhile.
module ising_local_energy_3d
    import ile3d_pkg::*;
#(
    parameter int unsigned EDGE_MAX = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // coord_x[3:0], coord_y[7:4], coord_z[11:8],
                                             // spin_up[12], zero pad
    input  logic                  s_tuser,   // action (0 write, 1 query)
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // site_energy[18:0], site_spin_up[19],
                                             // neighbour_count[22:20], zero pad
    output logic                  m_tuser,   // out_of_range
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned DEPTH    = EDGE_MAX * EDGE_MAX * EDGE_MAX;
    localparam int unsigned AW       = $clog2(DEPTH);
    localparam logic [AW-1:0] STRIDE_Y = AW'(EDGE_MAX);
    localparam logic [AW-1:0] STRIDE_Z = AW'(EDGE_MAX * EDGE_MAX);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [5:0]    EDGE_CAP  = 6'(EDGE_MAX);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [4:0]           grid_edge_reg;
    logic signed [15:0]   coupling_reg;

    logic [COORD_W-1:0]   cx_reg, cx_next;
    logic [COORD_W-1:0]   cy_reg, cy_next;
    logic [COORD_W-1:0]   cz_reg, cz_next;
    logic                 oor_reg, oor_next;
    logic [2:0]           slot_reg, slot_next;
    logic                 pend_reg, pend_next;      // a read is in flight
    logic                 pend_self_reg, pend_self_next;
    logic                 spin_reg, spin_next;
    logic signed [3:0]    sum_reg, sum_next;        // -6..6
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic signed [19:0]   prod_reg, prod_next;

    logic                 m_valid_reg, m_valid_next;
    logic [ENERGY_W-1:0]  m_energy_reg, m_energy_next;
    logic                 m_spin_reg, m_spin_next;
    logic [COUNT_W-1:0]   m_count_reg, m_count_next;
    logic                 m_oor_reg, m_oor_next;

    // ---------------------------------------------------------------
    // Spin store
    // ---------------------------------------------------------------
    logic          ram_en, ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0] ram_addr;

    ile3d_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Input decode and range check
    // ---------------------------------------------------------------
    logic [COORD_W-1:0] in_x, in_y, in_z;
    logic               in_spin;
    logic [5:0]         edge_eff;
    logic               in_oor;
    logic               s_xfer;

    assign in_x    = s_tdata[3:0];
    assign in_y    = s_tdata[7:4];
    assign in_z    = s_tdata[11:8];
    assign in_spin = s_tdata[12];

    // grid_edge above EDGE_MAX acts as EDGE_MAX
    assign edge_eff = ({1'b0, grid_edge_reg} > EDGE_CAP) ? EDGE_CAP : {1'b0, grid_edge_reg};
    assign in_oor   = ({2'b0, in_x} >= edge_eff) || ({2'b0, in_y} >= edge_eff)
                   || ({2'b0, in_z} >= edge_eff);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    function automatic logic [AW-1:0] site_addr(input logic [4:0] x, input logic [4:0] y,
                                                input logic [4:0] z);
        site_addr = AW'(x) + AW'(y) * STRIDE_Y + AW'(z) * STRIDE_Z;
    endfunction

    // ---------------------------------------------------------------
    // Neighbor selection for the current gather slot
    // ---------------------------------------------------------------
    logic [4:0] x5, y5, z5;
    logic [4:0] nx, ny, nz;
    logic       slot_ok;

    assign x5 = {1'b0, cx_reg};
    assign y5 = {1'b0, cy_reg};
    assign z5 = {1'b0, cz_reg};

    always_comb begin
        nx      = x5;
        ny      = y5;
        nz      = z5;
        slot_ok = 1'b0;
        unique case (slot_reg)
            SLOT_SELF: slot_ok = 1'b1;
            SLOT_XM: begin
                nx      = x5 - 5'd1;
                slot_ok = (cx_reg != '0);
            end
            SLOT_XP: begin
                nx      = x5 + 5'd1;
                slot_ok = ({1'b0, nx} < edge_eff);
            end
            SLOT_YM: begin
                ny      = y5 - 5'd1;
                slot_ok = (cy_reg != '0);
            end
            SLOT_YP: begin
                ny      = y5 + 5'd1;
                slot_ok = ({1'b0, ny} < edge_eff);
            end
            SLOT_ZM: begin
                nz      = z5 - 5'd1;
                slot_ok = (cz_reg != '0);
            end
            SLOT_ZP: begin
                nz      = z5 + 5'd1;
                slot_ok = ({1'b0, nz} < edge_eff);
            end
            SLOT_LAST: slot_ok = 1'b0;  // drain the last read only
            default:   slot_ok = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        oor_next       = oor_reg;
        slot_next      = slot_reg;
        pend_next      = 1'b0;
        pend_self_next = 1'b0;
        spin_next      = spin_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        prod_next      = prod_reg;

        m_valid_next   = m_valid_reg;
        m_energy_next  = m_energy_reg;
        m_spin_next    = m_spin_reg;
        m_count_next   = m_count_reg;
        m_oor_next     = m_oor_reg;

        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = clr_cnt_reg;
        ram_wdata = 1'b1;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                // all spins up after reset
                ram_en       = 1'b1;
                ram_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    cx_next  = in_x;
                    cy_next  = in_y;
                    cz_next  = in_z;
                    oor_next = in_oor;
                    if (s_tuser == ACT_WRITE) begin
                        // out-of-range writes are dropped
                        ram_en    = !in_oor;
                        ram_we    = 1'b1;
                        ram_addr  = site_addr({1'b0, in_x}, {1'b0, in_y}, {1'b0, in_z});
                        ram_wdata = in_spin;
                    end else if (in_oor) begin
                        state_next = ST_EMIT;
                    end else begin
                        slot_next  = SLOT_SELF;
                        sum_next   = '0;
                        count_next = '0;
                        state_next = ST_GATHER;
                    end
                end
            end
            ST_GATHER: begin
                // retire the read issued last cycle
                if (pend_reg) begin
                    if (pend_self_reg) begin
                        spin_next = ram_rdata;
                    end else begin
                        sum_next   = ram_rdata ? sum_reg + 4'sd1 : sum_reg - 4'sd1;
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                // issue the read for this slot
                if (slot_ok) begin
                    ram_en         = 1'b1;
                    ram_addr       = site_addr(nx, ny, nz);
                    pend_next      = 1'b1;
                    pend_self_next = (slot_reg == SLOT_SELF);
                end
                slot_next = slot_reg + 3'd1;
                if (slot_reg == SLOT_LAST) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                // operands sign-extended to the full product width
                prod_next  = 20'(coupling_reg) * 20'(sum_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_oor_next   = oor_reg;
                    if (oor_reg) begin
                        m_energy_next = '0;
                        m_spin_next   = 1'b0;
                        m_count_next  = '0;
                    end else begin
                        // E = -J * s * sum
                        m_energy_next = spin_reg ? ENERGY_W'(-prod_reg)
                                                 : ENERGY_W'(prod_reg);
                        m_spin_next   = spin_reg;
                        m_count_next  = count_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            pend_self_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pend_reg      <= pend_next;
            pend_self_reg <= pend_self_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        oor_reg      <= oor_next;
        slot_reg     <= slot_next;
        spin_reg     <= spin_next;
        sum_reg      <= sum_next;
        count_reg    <= count_next;
        prod_reg     <= prod_next;
        m_energy_reg <= m_energy_next;
        m_spin_reg   <= m_spin_next;
        m_count_reg  <= m_count_next;
        m_oor_reg    <= m_oor_next;
    end

    // ---------------------------------------------------------------
    // Configuration registers, always ready
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_edge_reg <= 5'd10;
            coupling_reg  <= 16'sd256;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_GRID_EDGE) begin
                grid_edge_reg <= cfg_data[4:0];
            end else begin
                coupling_reg  <= cfg_data;
            end
        end
    end

    // ---------------------------------------------------------------
    // Outputs
    // ---------------------------------------------------------------
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_spin_reg, m_energy_reg};
    assign m_tuser  = m_oor_reg;

endmodule

@@ src/ile3d_ram.sv @@
// Generic single-port RAM with registered read data.
module ile3d_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for ising_local_energy_3d: directed corner cases, then random spin traffic.
module testbench
    import ile3d_pkg::*;
();

    localparam int unsigned GRID_MAX      = 16;
    localparam int unsigned GRID_SITES    = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int unsigned MAX_WAIT      = 18;        // longest gap or stall per transfer
    localparam int unsigned SETTLE_CYCLES = 16;        // lets a trailing write or query finish
    localparam int unsigned RANDOM_ITEMS  = 1250;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned MAX_SHOWN     = 10;
    localparam longint      TIMEOUT_NS    = 10_000_000; // far past the slowest run

    // One query result, fields in the order they are compared
    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                spin_up;
        logic [COUNT_W-1:0]  count;
        logic                oor;
    } site_report_t;

    // Every block input holds a known value from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = ACT_WRITE;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = REG_GRID_EDGE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow of the block: spin grid plus both registers
    bit                    grid_spins [GRID_SITES];
    logic [4:0]            grid_edge_q;
    logic signed [15:0]    coupling_q;

    // Query results still owed by the block, oldest first
    site_report_t          energy_results_due [$];

    // Idle shaping: when set, that side never waits
    bit                    src_calm  = 1'b0;
    bit                    sink_calm = 1'b0;

    int unsigned           fault_count = 0;
    int unsigned           n_checked   = 0;
    int unsigned           n_writes    = 0;
    int unsigned           n_queries   = 0;
    int unsigned           n_outside   = 0;
    int unsigned           n_settings  = 0;

    ising_local_energy_3d #(
        .EDGE_MAX (GRID_MAX)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Store layout is fixed at GRID_MAX per axis, whatever edge is in use
    function automatic int unsigned site_addr(int unsigned x, int unsigned y, int unsigned z);
        return x + y * GRID_MAX + z * GRID_MAX * GRID_MAX;
    endfunction

    function automatic int spin_sign(int unsigned addr);
        return grid_spins[addr] ? 1 : -1;
    endfunction

    // Edges above the maximum clamp to it
    function automatic int unsigned edge_in_use();
        return (grid_edge_q > GRID_MAX) ? GRID_MAX : grid_edge_q;
    endfunction

    function automatic bit outside_grid(int unsigned x, int unsigned y, int unsigned z);
        int unsigned e;
        e = edge_in_use();
        return (x >= e) || (y >= e) || (z >= e);
    endfunction

    // E = -J * s * (sum of in-grid face neighbours), open faces, exact Q11.8
    function automatic site_report_t predict_site_energy(int unsigned x, int unsigned y,
                                                         int unsigned z);
        site_report_t r;
        int unsigned  e;
        int unsigned  n;
        int           s;
        int           sum;
        int           energy;
        r = '0;
        if (outside_grid(x, y, z)) begin
            r.oor = 1'b1;
            return r;
        end
        e   = edge_in_use();
        s   = spin_sign(site_addr(x, y, z));
        sum = 0;
        n   = 0;
        if (x > 0)     begin sum += spin_sign(site_addr(x - 1, y, z)); n++; end
        if (x + 1 < e) begin sum += spin_sign(site_addr(x + 1, y, z)); n++; end
        if (y > 0)     begin sum += spin_sign(site_addr(x, y - 1, z)); n++; end
        if (y + 1 < e) begin sum += spin_sign(site_addr(x, y + 1, z)); n++; end
        if (z > 0)     begin sum += spin_sign(site_addr(x, y, z - 1)); n++; end
        if (z + 1 < e) begin sum += spin_sign(site_addr(x, y, z + 1)); n++; end
        energy    = -(int'(coupling_q) * s * sum);
        r.energy  = energy[ENERGY_W-1:0];
        r.spin_up = (s > 0);
        r.count   = n[COUNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // One item over the input stream. Entered and left on a rising edge;
    // valid is dropped only when a gap follows, so back-to-back items keep
    // it high. The shadow is updated at the accepting edge.
    task automatic send_item(input logic action, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                             input logic up);
        int unsigned gap;
        int unsigned xi;
        int unsigned yi;
        int unsigned zi;
        xi  = 32'(x);
        yi  = 32'(y);
        zi  = 32'(z);
        gap = src_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {3'b000, up, z, y, x};
        do @(posedge aclk); while (!s_tready);

        if (action == ACT_WRITE) begin
            n_writes++;
            if (!outside_grid(xi, yi, zi))
                grid_spins[site_addr(xi, yi, zi)] = up;
        end else begin
            n_queries++;
            if (outside_grid(xi, yi, zi))
                n_outside++;
            energy_results_due.insert(energy_results_due.size(),
                                      predict_site_energy(xi, yi, zi));
        end
    endtask

    task automatic write_spin(input int unsigned x, input int unsigned y, input int unsigned z,
                              input logic up);
        send_item(ACT_WRITE, COORD_W'(x), COORD_W'(y), COORD_W'(z), up);
    endtask

    // spin_up has no meaning on a query, so it carries noise
    task automatic query_site(input int unsigned x, input int unsigned y, input int unsigned z);
        send_item(ACT_QUERY, COORD_W'(x), COORD_W'(y), COORD_W'(z), 1'($urandom_range(0, 1)));
    endtask

    // Stop feeding, collect every owed result, then let a trailing write
    // or an empty query finish before anything touches the registers
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (energy_results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Both registers in two transfers; valid stays up between them
    task automatic write_regs(input logic [4:0] grid_edge, input logic [15:0] coupling);
        cfg_valid <= 1'b1;
        cfg_index <= REG_GRID_EDGE;
        cfg_data  <= {11'b0, grid_edge};
        do @(posedge aclk); while (!cfg_ready);
        grid_edge_q = grid_edge;
        cfg_index <= REG_COUPLING;
        cfg_data  <= coupling;
        do @(posedge aclk); while (!cfg_ready);
        coupling_q = coupling;
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Sink: random stall before each transfer, ready held until it happens
    initial begin : result_sink
        int unsigned stall;
        forever begin
            stall = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Every result transfer against the oldest owed report
    always @(posedge aclk) begin : check_results
        site_report_t due;
        site_report_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[18:0], m_tdata[19], m_tdata[22:20], m_tuser};
            if (energy_results_due.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_SHOWN)
                    $display("%0t: result with none owed: energy %0d spin %0b count %0d oor %0b",
                             $realtime, $signed(got.energy), got.spin_up, got.count, got.oor);
            end else begin
                due = energy_results_due.pop_front();
                n_checked++;
                if (got !== due) begin
                    fault_count++;
                    if (fault_count <= MAX_SHOWN) begin
                        $display("%0t: mismatch energy %0d/%0d spin %0b/%0b (expected/actual)",
                                 $realtime, $signed(due.energy), $signed(got.energy),
                                 due.spin_up, got.spin_up);
                        $display("    count %0d/%0d  oor %0b/%0b",
                                 due.count, got.count, due.oor, got.oor);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset state: all spins up, edge 10, J = 1.0
    task automatic test_default_grid();
        query_site(0, 0, 0);     // corner, three neighbours
        query_site(5, 5, 5);     // interior, six neighbours
        query_site(9, 9, 9);     // far corner of the default grid
        query_site(10, 0, 0);    // first coordinate past the edge
        query_site(15, 15, 15);  // all coordinates at field maximum
    endtask

    // Flipped spins show in the site itself and in its neighbours
    task automatic test_spin_writes();
        write_spin(1, 1, 1, 1'b0);
        query_site(1, 1, 1);     // down among up: positive energy
        write_spin(0, 1, 1, 1'b0);
        query_site(1, 1, 1);
        write_spin(12, 3, 3, 1'b0); // outside edge 10, must be dropped
        query_site(12, 3, 3);
    endtask

    // Register extremes and the degenerate edges
    task automatic test_edge_settings();
        wait_idle();
        write_regs(5'd16, 16'h7FFF);     // full grid, largest positive J
        query_site(15, 15, 15);
        write_spin(15, 15, 14, 1'b0);
        query_site(15, 15, 15);
        query_site(12, 3, 3);            // earlier dropped write left it up

        wait_idle();
        write_regs(5'd2, 16'h8000);      // smallest grid with face neighbours, most negative J
        query_site(1, 1, 1);
        query_site(2, 0, 0);

        wait_idle();
        write_regs(5'd1, 16'h0100);      // one site, no neighbours, energy 0
        query_site(0, 0, 0);

        wait_idle();
        write_regs(5'd0, 16'h0100);      // empty grid: all out of range
        write_spin(0, 0, 0, 1'b0);
        query_site(0, 0, 0);

        wait_idle();
        write_regs(5'd31, 16'hFF00);     // above maximum acts as 16
        query_site(15, 0, 0);
    endtask

    // Mostly in-grid traffic so writes reshape the neighbourhoods that
    // queries read, with some out-of-grid noise mixed in
    task automatic test_random_traffic();
        int unsigned per_phase;
        int unsigned done;
        int unsigned e;
        logic [4:0]  grid_edge;
        logic [15:0] coupling;
        logic        action;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  z;
        per_phase = RANDOM_ITEMS / RANDOM_PHASES;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    grid_edge = 5'd16;
                    coupling  = 16'h7FFF;
                end
                1: begin
                    grid_edge = 5'($urandom_range(2, 5));
                    coupling  = 16'h8000;
                end
                2: begin
                    grid_edge = 5'($urandom_range(17, 31));
                    coupling  = 16'($urandom());
                end
                3: begin
                    grid_edge = 5'd2;
                    coupling  = 16'h0001;
                end
                4: begin
                    grid_edge = 5'($urandom_range(2, 16));
                    coupling  = 16'($urandom());
                end
                default: begin
                    grid_edge = 5'($urandom_range(6, 12));
                    coupling  = 16'($urandom());
                end
            endcase
            wait_idle();
            write_regs(grid_edge, coupling);
            e    = edge_in_use();
            done = 0;
            while (done < per_phase) begin
                // re-draw idle behavior in stretches; two phases run one side flat out
                if (done % 40 == 0) begin
                    src_calm  = (phase == 1) || ($urandom_range(0, 3) == 0);
                    sink_calm = (phase == 2) || ($urandom_range(0, 3) == 0);
                end
                action = ($urandom_range(0, 99) < 55) ? ACT_QUERY : ACT_WRITE;
                if (e == 0 || $urandom_range(0, 15) == 0) begin
                    x = 4'($urandom_range(0, 15));
                    y = 4'($urandom_range(0, 15));
                    z = 4'($urandom_range(0, 15));
                end else begin
                    x = 4'($urandom_range(0, e - 1));
                    y = 4'($urandom_range(0, e - 1));
                    z = 4'($urandom_range(0, e - 1));
                end
                // dropped writes do nothing, so they do not count
                if (!(action == ACT_WRITE && outside_grid(32'(x), 32'(y), 32'(z))))
                    done++;
                send_item(action, x, y, z, 1'($urandom_range(0, 1)));
            end
        end
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin : run_tests
        foreach (grid_spins[i])
            grid_spins[i] = 1'b1;
        grid_edge_q = 5'd10;
        coupling_q  = 16'sh0100;

        // synchronous reset; the block then clears its store on its own
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_grid();
        test_spin_writes();
        test_edge_settings();
        test_random_traffic();
        wait_idle();

        $display("testbench: %0d writes and %0d queries (%0d outside the grid) over %0d settings",
                 n_writes, n_queries, n_outside, n_settings);
        $display("testbench: %0d results compared, %0d faults", n_checked, fault_count);
        if (fault_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Hang guard
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
src/ile3d_pkg.sv
src/ile3d_ram.sv
src/ising_local_energy_3d.sv
test/testbench.sv
